// ===== sv/crds_pkg.sv =====
// crds_pkg: shared types, widths and constants of the co-rated dot similarity block.
// No dependencies; imported by every module of the block.
package crds_pkg;

	// table capacity per user
	localparam int MAX_PER_USER = 256;

	localparam int ID_W     = 20;
	localparam int RATING_W = 4;
	localparam int OFS_W    = 5;
	localparam int SIM_W    = 18;

	localparam int ADDR_W   = $clog2(MAX_PER_USER);
	localparam int CNT_W    = $clog2(MAX_PER_USER + 1);
	localparam int ENTRY_W  = ID_W + RATING_W;
	// offset rating spans -16..30, product of two fits a signed 12-bit value
	localparam int TERM_W   = RATING_W + 2;
	localparam int PROD_W   = 2 * TERM_W;
	localparam int ACC_RAW  = ADDR_W + PROD_W;
	localparam int ACC_W    = (ACC_RAW > SIM_W) ? ACC_RAW : SIM_W + 1;

	// register map
	localparam int REG_IDX_W = 2;
	localparam int APB_AW    = REG_IDX_W + 2;
	localparam int APB_DW    = 32;
	localparam logic [REG_IDX_W-1:0] REG_USER_A = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_USER_B = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_OFFSET = 2'd2;

	localparam logic [ID_W-1:0]         RST_USER_A = ID_W'(0);
	localparam logic [ID_W-1:0]         RST_USER_B = ID_W'(1);
	localparam logic signed [OFS_W-1:0] RST_OFFSET = -5'sd5;

	typedef struct packed {
		logic [ID_W-1:0]     user_id;
		logic [ID_W-1:0]     movie_id;
		logic [RATING_W-1:0] rating_value;
		logic                last;
	} rec_t;

	typedef struct packed {
		logic signed [SIM_W-1:0] similarity;
		logic                    overflow;
	} sim_t;

	typedef struct packed {
		logic [ID_W-1:0]         user_a;
		logic [ID_W-1:0]         user_b;
		logic signed [OFS_W-1:0] rating_offset;
	} cfg_t;

	// controller -> datapath
	typedef struct packed {
		logic store;   // write accepted record into the tables
		logic fetch;   // read first[i], second[0]
		logic scan;    // read second[j], advance j
		logic acc;     // add product of current pair
		logic next_i;  // advance to next first-table entry
		logic emit;    // load result register, clear tables
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic empty;
		logic match;
		logic b_last;
		logic i_last;
		logic out_busy;
	} st_t;

endpackage

// ===== sv/co_rated_dot_similarity.sv =====
// co_rated_dot_similarity: top level of the co-rated dot product similarity block.
// Depends on crds_pkg, crds_regs, crds_ctrl, crds_dp.
//
// Rating records enter on rec_valid/rec_stall/rec_data, one beat per cycle while idle.
// Records of user_a go to the first table, of user_b to the second (both when equal);
// others are ignored. A table takes MAX_PER_USER records; extra ones are dropped and
// set the overflow bit of the next result.
// The beat with last=1 is stored, then the block walks the tables: for each first-table
// entry it reads the second table from its start until the movie matches or the table
// ends, one entry per cycle on the second table's read port.
// The result beat (similarity, overflow) stays in an output register until taken;
// sim_stall holds it there, and the walk of a following data set waits in its final
// state while the previous result is still held. Records are not taken during a walk.
// After the result loads, tables, counts and the overflow flag are clear again.
// Reset: tables empty, user_a=0, user_b=1, rating_offset=-5, no result pending.
// Config must be written over the APB-style port only while the block is idle; the block itself does not enforce this.
module co_rated_dot_similarity
	import crds_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	input  logic              rec_valid,
	output logic              rec_stall,
	input  rec_t              rec_data,
	output logic              sim_valid,
	input  logic              sim_stall,
	output sim_t              sim_data
);

	cfg_t cfg;
	cmd_t cmd;
	st_t  st;

	crds_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	crds_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_valid (rec_valid),
		.rec_last  (rec_data.last),
		.rec_stall (rec_stall),
		.st        (st),
		.cmd       (cmd)
	);

	crds_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.rec       (rec_data),
		.cmd       (cmd),
		.st        (st),
		.sim_valid (sim_valid),
		.sim_stall (sim_stall),
		.sim_data  (sim_data)
	);

endmodule

// ===== sv/crds_regs.sv =====
// crds_regs: APB-style configuration registers (user_a, user_b, rating_offset).
// Depends on crds_pkg.
module crds_regs
	import crds_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic [ID_W-1:0]         user_a_q;
	logic [ID_W-1:0]         user_b_q;
	logic signed [OFS_W-1:0] offset_q;
	logic [REG_IDX_W-1:0]    idx;
	logic                    wr_en;

	assign idx    = paddr[APB_AW-1:2];
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			user_a_q <= RST_USER_A;
			user_b_q <= RST_USER_B;
			offset_q <= RST_OFFSET;
		end else if (wr_en) begin
			unique case (idx)
				REG_USER_A: user_a_q <= pwdata[ID_W-1:0];
				REG_USER_B: user_b_q <= pwdata[ID_W-1:0];
				REG_OFFSET: offset_q <= pwdata[OFS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_USER_A: prdata = APB_DW'(user_a_q);
			REG_USER_B: prdata = APB_DW'(user_b_q);
			REG_OFFSET: prdata = APB_DW'(unsigned'(offset_q));
			default:    prdata = '0;
		endcase
	end

	assign cfg.user_a        = user_a_q;
	assign cfg.user_b        = user_b_q;
	assign cfg.rating_offset = offset_q;

endmodule

// ===== sv/crds_dp.sv =====
// crds_dp: rating tables, walk counters, multiply-accumulate and result register.
// Depends on crds_pkg; driven by crds_ctrl through cmd_t / st_t.
module crds_dp
	import crds_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  rec_t rec,
	input  cmd_t cmd,
	output st_t  st,
	output logic sim_valid,
	input  logic sim_stall,
	output sim_t sim_data
);

	logic [ENTRY_W-1:0] first_mem  [MAX_PER_USER];
	logic [ENTRY_W-1:0] second_mem [MAX_PER_USER];

	logic [CNT_W-1:0]        fcount_q, scount_q, i_q, j_q;
	logic                    dropped_q;
	logic                    blast_q;
	logic [ENTRY_W-1:0]      a_rd_q, b_rd_q;
	logic signed [ACC_W-1:0] acc_q;
	logic                    sim_valid_q;
	sim_t                    sim_q;

	logic                    hit_a, hit_b, wr_a, wr_b, drop;
	logic [CNT_W-1:0]        b_rd_idx;
	logic signed [TERM_W-1:0] term_a, term_b;
	logic signed [PROD_W-1:0] prod;
	logic signed [ACC_W-1:0] sat_hi, sat_lo;
	logic signed [SIM_W-1:0] sim_sat;
	logic [ENTRY_W-1:0]      rec_entry;

	assign hit_a = cmd.store && (rec.user_id == cfg.user_a);
	assign hit_b = cmd.store && (rec.user_id == cfg.user_b);
	assign wr_a  = hit_a && (fcount_q != CNT_W'(MAX_PER_USER));
	assign wr_b  = hit_b && (scount_q != CNT_W'(MAX_PER_USER));
	assign drop  = (hit_a && !wr_a) || (hit_b && !wr_b);
	assign rec_entry = {rec.movie_id, rec.rating_value};

	always_ff @(posedge clk) begin
		if (wr_a)
			first_mem[fcount_q[ADDR_W-1:0]] <= rec_entry;
		if (cmd.fetch)
			a_rd_q <= first_mem[i_q[ADDR_W-1:0]];
	end

	assign b_rd_idx = cmd.fetch ? '0 : j_q;

	always_ff @(posedge clk) begin
		if (wr_b)
			second_mem[scount_q[ADDR_W-1:0]] <= rec_entry;
		if (cmd.fetch || cmd.scan)
			b_rd_q <= second_mem[b_rd_idx[ADDR_W-1:0]];
	end

	// offset ratings and their product
	assign term_a = $signed({2'b00, a_rd_q[RATING_W-1:0]}) + TERM_W'(cfg.rating_offset);
	assign term_b = $signed({2'b00, b_rd_q[RATING_W-1:0]}) + TERM_W'(cfg.rating_offset);
	assign prod   = term_a * term_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fcount_q  <= '0;
			scount_q  <= '0;
			dropped_q <= 1'b0;
			i_q       <= '0;
			j_q       <= '0;
			blast_q   <= 1'b0;
			acc_q     <= '0;
		end else begin
			if (cmd.emit) begin
				fcount_q  <= '0;
				scount_q  <= '0;
				dropped_q <= 1'b0;
				i_q       <= '0;
				acc_q     <= '0;
			end else begin
				if (wr_a)
					fcount_q <= fcount_q + CNT_W'(1);
				if (wr_b)
					scount_q <= scount_q + CNT_W'(1);
				if (drop)
					dropped_q <= 1'b1;
				if (cmd.next_i)
					i_q <= i_q + CNT_W'(1);
				if (cmd.acc)
					acc_q <= acc_q + ACC_W'(prod);
			end
			if (cmd.fetch) begin
				j_q     <= CNT_W'(1);
				blast_q <= (scount_q == CNT_W'(1));
			end else if (cmd.scan) begin
				j_q     <= j_q + CNT_W'(1);
				blast_q <= ((j_q + CNT_W'(1)) == scount_q);
			end
		end
	end

	// saturate to the result width
	assign sat_hi = $signed({{(ACC_W-SIM_W+1){1'b0}}, {(SIM_W-1){1'b1}}});
	assign sat_lo = $signed({{(ACC_W-SIM_W+1){1'b1}}, {(SIM_W-1){1'b0}}});

	always_comb begin
		priority if (acc_q > sat_hi)
			sim_sat = sat_hi[SIM_W-1:0];
		else if (acc_q < sat_lo)
			sim_sat = sat_lo[SIM_W-1:0];
		else
			sim_sat = acc_q[SIM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sim_valid_q <= 1'b0;
		else if (cmd.emit)
			sim_valid_q <= 1'b1;
		else if (!sim_stall)
			sim_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			sim_q.similarity <= sim_sat;
			sim_q.overflow   <= dropped_q;
		end
	end

	assign sim_valid = sim_valid_q;
	assign sim_data  = sim_q;

	assign st.empty    = (fcount_q == '0) || (scount_q == '0);
	assign st.match    = (a_rd_q[ENTRY_W-1:RATING_W] == b_rd_q[ENTRY_W-1:RATING_W]);
	assign st.b_last   = blast_q;
	assign st.i_last   = ((i_q + CNT_W'(1)) == fcount_q);
	assign st.out_busy = sim_valid_q && sim_stall;

	a_fcount_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fcount_q <= CNT_W'(MAX_PER_USER) && scount_q <= CNT_W'(MAX_PER_USER))
		else $error("table count beyond capacity");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan |-> j_q < scount_q)
		else $error("second-table read past its count");

	a_result_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sim_valid_q) |-> $past(cmd.emit))
		else $error("result beat without emit");

endmodule

// ===== sv/crds_ctrl.sv =====
// crds_ctrl: sequencer for record loading and the co-rated table walk.
// Depends on crds_pkg; commands crds_dp through cmd_t, reads st_t.
module crds_ctrl
	import crds_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic rec_valid,
	input  logic rec_last,
	output logic rec_stall,
	input  st_t  st,
	output cmd_t cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_START = 3'd1;
	localparam logic [2:0] S_FETCH = 3'd2;
	localparam logic [2:0] S_SCAN  = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0] state_q, state_d;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		rec_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				rec_stall = 1'b0;
				cmd.store = rec_valid;
				if (rec_valid && rec_last)
					state_d = S_START;
			end
			S_START: begin
				state_d = st.empty ? S_DONE : S_FETCH;
			end
			S_FETCH: begin
				cmd.fetch = 1'b1;
				state_d   = S_SCAN;
			end
			S_SCAN: begin
				cmd.acc = st.match;
				if (st.match || st.b_last) begin
					if (st.i_last)
						state_d = S_DONE;
					else begin
						cmd.next_i = 1'b1;
						state_d    = S_FETCH;
					end
				end else
					cmd.scan = 1'b1;
			end
			S_DONE: begin
				if (!st.out_busy) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !st.out_busy)
		else $error("emit while result register still held");

	a_last_starts_walk: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store && rec_last |=> state_q == S_START)
		else $error("last record did not start the walk");

	a_walk_no_store: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.fetch || cmd.scan || cmd.acc) |-> !cmd.store && !cmd.emit)
		else $error("walk overlaps record load or emit");

endmodule
